[hw/rtl/ptc_pkg.sv]
// Package for the playback transport controller.
// Event and state codes, status codes and the control flag bundle.
// No dependencies.
`default_nettype none

package ptc_pkg;

   localparam int ACTION_BITS = 4;
   localparam int GAIN_BITS   = 16;
   localparam int RATE_BITS   = 32;

   localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'd16384;
   localparam logic [RATE_BITS-1:0] RATE_UNITY = 32'h0001_0000;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_LOAD      = 4'd0,
      ACT_READY     = 4'd1,
      ACT_PLAY      = 4'd2,
      ACT_PAUSE     = 4'd3,
      ACT_SEEK      = 4'd4,
      ACT_LOOP_RNG  = 4'd5,
      ACT_LOOP_EN   = 4'd6,
      ACT_XFADE     = 4'd7,
      ACT_RATE      = 4'd8,
      ACT_GAIN      = 4'd9,
      ACT_RESET     = 4'd10,
      ACT_END       = 4'd11
   } action_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_LOADING = 3'd1,
      MODE_READY   = 3'd2,
      MODE_PLAYING = 3'd3,
      MODE_PAUSED  = 3'd4,
      MODE_SEEKING = 3'd5,
      MODE_ENDED   = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_NOTIMPL = 2'd2
   } status_type;

   typedef struct packed {
      mode_type mode;
      logic     resume;
      logic     dur_known;
      logic     fade;
      logic     loop_on;
   } flags_type;

endpackage

`default_nettype wire

[hw/rtl/ptc_update.sv]
// Next-state and status logic for one transport event.
// Depends on ptc_pkg.
`default_nettype none

module ptc_update #(
   parameter int FRAME_BITS = 48
) (
   input  ptc_pkg::action_type             action,
   input  logic [FRAME_BITS-1:0]           frame_value,
   input  logic [FRAME_BITS-1:0]           range_begin,
   input  logic [FRAME_BITS-1:0]           range_end,
   input  logic                            enable_flag,
   input  logic [ptc_pkg::RATE_BITS-1:0]   rate_value,
   input  logic [ptc_pkg::GAIN_BITS-1:0]   gain_value,
   input  ptc_pkg::flags_type              flags_cur,
   input  logic [FRAME_BITS-2:0]           cursor_cur,
   input  logic [FRAME_BITS-1:0]           duration_cur,
   input  logic [FRAME_BITS-1:0]           loop_start_cur,
   input  logic [FRAME_BITS-1:0]           loop_stop_cur,
   input  logic [FRAME_BITS-2:0]           xfade_cur,
   input  logic [ptc_pkg::GAIN_BITS-1:0]   gain_cur,
   output ptc_pkg::status_type             status,
   output ptc_pkg::flags_type              flags_nxt,
   output logic [FRAME_BITS-2:0]           cursor_nxt,
   output logic [FRAME_BITS-1:0]           duration_nxt,
   output logic [FRAME_BITS-1:0]           loop_start_nxt,
   output logic [FRAME_BITS-1:0]           loop_stop_nxt,
   output logic [FRAME_BITS-2:0]           xfade_nxt,
   output logic [ptc_pkg::GAIN_BITS-1:0]   gain_nxt
);
   import ptc_pkg::*;

   logic [FRAME_BITS-1:0] limit;
   logic [FRAME_BITS-1:0] target;
   logic                  frame_neg;

   assign frame_neg = frame_value[FRAME_BITS-1];
   assign limit     = (flags_cur.dur_known && !duration_cur[FRAME_BITS-1]) ?
                      duration_cur : '0;
   assign target    = frame_neg ? '0 : ((frame_value > limit) ? limit : frame_value);

   always_comb begin
      status         = ST_OK;
      flags_nxt      = flags_cur;
      cursor_nxt     = cursor_cur;
      duration_nxt   = duration_cur;
      loop_start_nxt = loop_start_cur;
      loop_stop_nxt  = loop_stop_cur;
      xfade_nxt      = xfade_cur;
      gain_nxt       = gain_cur;
      case (action)
         ACT_LOAD: begin
            if (flags_cur.mode == MODE_IDLE || flags_cur.mode == MODE_ENDED) begin
               flags_nxt.mode      = MODE_LOADING;
               flags_nxt.dur_known = 1'b0;
               duration_nxt        = '0;
               cursor_nxt          = '0;
            end else begin
               status = ST_INVALID;
            end
         end
         ACT_READY: begin
            if (flags_cur.mode == MODE_LOADING) begin
               flags_nxt.mode      = MODE_READY;
               flags_nxt.dur_known = 1'b1;
               duration_nxt        = frame_value;
            end else begin
               status = ST_INVALID;
            end
         end
         ACT_PLAY: begin
            if (flags_cur.mode == MODE_READY || flags_cur.mode == MODE_PAUSED) begin
               flags_nxt.mode = MODE_PLAYING;
            end else if (flags_cur.mode != MODE_PLAYING) begin
               status = ST_INVALID;
            end
         end
         ACT_PAUSE: begin
            if (flags_cur.mode == MODE_PLAYING) begin
               flags_nxt.mode = MODE_PAUSED;
            end else if (flags_cur.mode != MODE_PAUSED) begin
               status = ST_INVALID;
            end
         end
         ACT_SEEK: begin
            if (flags_cur.mode == MODE_PLAYING || flags_cur.mode == MODE_PAUSED ||
                flags_cur.mode == MODE_READY || flags_cur.mode == MODE_ENDED) begin
               flags_nxt.resume = (flags_cur.mode == MODE_PLAYING);
               flags_nxt.mode   = MODE_SEEKING;
               flags_nxt.fade   = 1'b1;
               cursor_nxt       = target[FRAME_BITS-2:0];
            end else begin
               status = ST_INVALID;
            end
         end
         ACT_LOOP_RNG: begin
            loop_start_nxt = range_begin;
            loop_stop_nxt  = range_end;
         end
         ACT_LOOP_EN: begin
            flags_nxt.loop_on = enable_flag;
         end
         ACT_XFADE: begin
            xfade_nxt = frame_neg ? '0 : frame_value[FRAME_BITS-2:0];
         end
         ACT_RATE: begin
            if (rate_value != RATE_UNITY) begin
               status = ST_NOTIMPL;
            end
         end
         ACT_GAIN: begin
            gain_nxt = gain_value;
         end
         ACT_RESET: begin
            flags_nxt.mode      = MODE_IDLE;
            flags_nxt.dur_known = 1'b0;
            flags_nxt.loop_on   = 1'b0;
            cursor_nxt          = '0;
            duration_nxt        = '0;
            loop_start_nxt      = '0;
            loop_stop_nxt       = '0;
            gain_nxt            = GAIN_UNITY;
         end
         ACT_END: begin
            if (flags_cur.mode == MODE_PLAYING) begin
               flags_nxt.mode = MODE_ENDED;
            end else begin
               status = ST_INVALID;
            end
         end
         default: begin
            status = ST_INVALID;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/playback_transport_controller.sv]
// Top level of the playback transport controller: event register, transport
// state registers and result register. Depends on ptc_pkg and ptc_update.
//
//   channel  dir  tdata                                   tuser
//   req_     in   frame, loop begin/end, enable, rate, gain  action
//   rsp_     out  status and state snapshot               -
//
// One event per cycle while rsp_tready is high; a req beat goes to the event
// register, its result to the result register. The event register feeds the
// update logic, which writes state and result registers in the same cycle.
// A stalled rsp beat holds the event register; req_tready stays high while it
// can drain. Synchronous reset clears the state to idle with unity gain.
`default_nettype none

module playback_transport_controller #(
   parameter int FRAME_BITS = 48
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // bits lo->hi: frame_value, range_begin, range_end, enable_flag, rate_value,
   // gain_value, zero fill
   input  logic [((3*FRAME_BITS+ptc_pkg::RATE_BITS+ptc_pkg::GAIN_BITS+1+7)/8)*8-1:0]
                req_tdata,
   // bits lo->hi: action
   input  logic [ptc_pkg::ACTION_BITS-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // bits lo->hi: status_code, play_state, cursor_out, duration_out,
   // duration_known, fade_pending, resume_playing, loop_on, loop_start_out,
   // loop_stop_out, crossfade_out, gain_out, zero fill
   output logic [((5*FRAME_BITS+ptc_pkg::GAIN_BITS+7+7)/8)*8-1:0] rsp_tdata
);
   import ptc_pkg::*;

   localparam int F      = FRAME_BITS;
   localparam int IN_W   = ((3*F+RATE_BITS+GAIN_BITS+1+7)/8)*8;
   localparam int OUT_R  = 5*F+GAIN_BITS+7;
   localparam int OUT_W  = ((OUT_R+7)/8)*8;
   localparam int IN_R   = 3*F+RATE_BITS+GAIN_BITS+1;

   logic                  ev_valid_ff, ev_valid_in;
   logic [IN_W-1:0]       ev_data_ff;
   logic [ACTION_BITS-1:0] ev_act_ff;
   logic                  advance;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_data_ff, rsp_data_in;

   flags_type             flags_ff, flags_in;
   logic [F-2:0]          cursor_ff, cursor_in;
   logic [F-1:0]          duration_ff, duration_in;
   logic [F-1:0]          loop_start_ff, loop_start_in;
   logic [F-1:0]          loop_stop_ff, loop_stop_in;
   logic [F-2:0]          xfade_ff, xfade_in;
   logic [GAIN_BITS-1:0]  gain_ff, gain_in;
   status_type            status;

   assign advance     = ev_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !ev_valid_ff || advance;
   assign ev_valid_in = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : ev_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         flags_ff      <= '{mode: MODE_IDLE, resume: 1'b0, dur_known: 1'b0,
                            fade: 1'b0, loop_on: 1'b0};
         cursor_ff     <= '0;
         duration_ff   <= '0;
         loop_start_ff <= '0;
         loop_stop_ff  <= '0;
         xfade_ff      <= '0;
         gain_ff       <= GAIN_UNITY;
      end else begin
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            flags_ff      <= flags_in;
            cursor_ff     <= cursor_in;
            duration_ff   <= duration_in;
            loop_start_ff <= loop_start_in;
            loop_stop_ff  <= loop_stop_in;
            xfade_ff      <= xfade_in;
            gain_ff       <= gain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ev_data_ff <= req_tdata;
         ev_act_ff  <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   ptc_update #(
      .FRAME_BITS(F)
   ) u_update (
      .action         (action_type'(ev_act_ff)),
      .frame_value    (ev_data_ff[F-1:0]),
      .range_begin    (ev_data_ff[2*F-1:F]),
      .range_end      (ev_data_ff[3*F-1:2*F]),
      .enable_flag    (ev_data_ff[3*F]),
      .rate_value     (ev_data_ff[3*F+RATE_BITS:3*F+1]),
      .gain_value     (ev_data_ff[IN_R-1:3*F+RATE_BITS+1]),
      .flags_cur      (flags_ff),
      .cursor_cur     (cursor_ff),
      .duration_cur   (duration_ff),
      .loop_start_cur (loop_start_ff),
      .loop_stop_cur  (loop_stop_ff),
      .xfade_cur      (xfade_ff),
      .gain_cur       (gain_ff),
      .status         (status),
      .flags_nxt      (flags_in),
      .cursor_nxt     (cursor_in),
      .duration_nxt   (duration_in),
      .loop_start_nxt (loop_start_in),
      .loop_stop_nxt  (loop_stop_in),
      .xfade_nxt      (xfade_in),
      .gain_nxt       (gain_in)
   );

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[OUT_R-1:0] = {gain_in, xfade_in, loop_stop_in, loop_start_in,
                                flags_in.loop_on, flags_in.resume, flags_in.fade,
                                flags_in.dur_known, duration_in, cursor_in,
                                flags_in.mode, status};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_advance_gives_beat: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("event advanced without a result beat");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flags_ff) && $stable(cursor_ff))
      else $error("transport state moved without an event");

   a_cursor_unknown: assert property (@(posedge clock) disable iff (reset)
      (!flags_ff.dur_known || duration_ff[F-1]) |-> (cursor_ff == '0))
      else $error("cursor nonzero without a usable duration");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (flags_ff.dur_known && !duration_ff[F-1]) |-> ({1'b0, cursor_ff} <= duration_ff))
      else $error("cursor beyond duration");

endmodule

`default_nettype wire
